/* hdl/color_table_lookup_or_insert_macros.svh */
// assertion macros for the color table lookup-or-insert block
`ifndef COLOR_TABLE_LOOKUP_OR_INSERT_MACROS_SVH
`define COLOR_TABLE_LOOKUP_OR_INSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CTLU_ASSERT_SAME(label, rst, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst)) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CTLU_ASSERT_NEXT(label, rst, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst)) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/ctlu_pkg.sv */
// shared types and constants for the color table lookup-or-insert block
package ctlu_pkg;

    localparam int CAPACITY_DEFAULT = 256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [7:0] index;
        logic       was_added;
        logic       table_full;
    } result_t;

    typedef struct packed {
        logic load_key;
        logic step;
        logic finish;
    } ctlu_cmd_t;

    typedef struct packed {
        logic match;
        logic exhausted;
        logic full;
    } ctlu_status_t;

endpackage

/* hdl/ctlu_ctrl.sv */
// controller state machine for the color table scan
module ctlu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ctlu_pkg::ctlu_cmd_t   cmd,
    input  ctlu_pkg::ctlu_status_t status
);
    import ctlu_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   done;

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign done         = status.match || status.exhausted;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    // hold the decision until the output register is free
                    if (slot_free)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/ctlu_datapath.sv */
// color store, scan counters, compare and result register
module ctlu_datapath #(
    parameter int CAPACITY = ctlu_pkg::CAPACITY_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctlu_pkg::color_t       pixel,
    output ctlu_pkg::result_t      result,
    input  ctlu_pkg::ctlu_cmd_t    cmd,
    output ctlu_pkg::ctlu_status_t status
);
    import ctlu_pkg::*;

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);

    logic [23:0]     mem [CAPACITY];
    logic [23:0]     rdata_reg;
    color_t          key_reg;
    result_t         result_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic [CNTW-1:0] rd_cnt_reg;
    logic [CNTW-1:0] rd_cnt_next;
    logic            cmp_valid_reg;
    logic            cmp_valid_next;
    logic [CNTW-1:0] cmp_idx_reg;
    logic            issue;
    logic            append;

    assign issue  = cmd.step && (rd_cnt_reg != count_reg);
    assign append = cmd.finish && !status.match && !status.full;

    assign status.match     = cmp_valid_reg && (rdata_reg == key_reg);
    assign status.exhausted = !cmp_valid_reg && (rd_cnt_reg == count_reg);
    assign status.full      = (count_reg == CNTW'(CAPACITY));

    assign result = result_reg;

    always_comb
    begin
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.load_key)
        begin
            rd_cnt_next    = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.step)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
        end
        if (append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            mem[count_reg[IDXW-1:0]] <= key_reg;
        end
        if (issue)
        begin
            rdata_reg   <= mem[rd_cnt_reg[IDXW-1:0]];
            cmp_idx_reg <= rd_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= pixel;
        end
        if (cmd.finish)
        begin
            if (status.match)
            begin
                result_reg.index      <= 8'(cmp_idx_reg);
                result_reg.was_added  <= 1'b0;
                result_reg.table_full <= 1'b0;
            end
            else if (status.full)
            begin
                result_reg.index      <= 8'd0;
                result_reg.was_added  <= 1'b0;
                result_reg.table_full <= 1'b1;
            end
            else
            begin
                result_reg.index      <= 8'(count_reg);
                result_reg.was_added  <= 1'b1;
                result_reg.table_full <= 1'b0;
            end
        end
    end

endmodule

/* hdl/color_table_lookup_or_insert.sv */
// top level of the color table lookup-or-insert block
// Palette builder: each color transfer is compared against the stored
// entries one per cycle, lowest index first, through the single read port of
// the color store. A color found at index i answers once the entries up to i
// have been compared; a color that is appended, or that meets a full table,
// answers once all count stored entries have been compared. A stalled result
// that still waits in the output register holds back the next answer until
// it is taken. One color is in work at a time; pixel_stall stays high from
// the transfer until the answer is loaded into the output register, and the
// next color is taken while that answer still waits. Index reports the low
// 8 bits of the table index. The store needs no clearing after reset: only
// entries below the count are ever read.
module color_table_lookup_or_insert #(
    parameter int CAPACITY = ctlu_pkg::CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  ctlu_pkg::color_t  pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output ctlu_pkg::result_t result
);
    import ctlu_pkg::*;

`include "color_table_lookup_or_insert_macros.svh"

    ctlu_cmd_t    cmd;
    ctlu_status_t status;

    ctlu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    ctlu_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

    `CTLU_ASSERT_NEXT(a_busy_after_transfer, rst_n, pixel_valid && !pixel_stall, pixel_stall, "block not busy after color transfer")
    `CTLU_ASSERT_NEXT(a_finish_shows_result, rst_n, cmd.finish, result_valid && (result.was_added != result.table_full || !result.table_full), "no result after scan finish")
    `CTLU_ASSERT_SAME(a_one_command, rst_n, 1'b1, $onehot0({cmd.load_key, cmd.step, cmd.finish}), "controller issued more than one command")
    `CTLU_ASSERT_SAME(a_full_flags, rst_n, result_valid && result.table_full, !result.was_added && (result.index == 8'd0), "full result carries an index or add flag")

endmodule
